[hdl/sssm_pkg.sv]
// ----------------------------------------------------------------------------
// sssm_pkg
// Shared types and codes of the scrolling seven-segment display driver.
// ----------------------------------------------------------------------------
package sssm_pkg;

  localparam int IDX_W   = 6;   // digit index field
  localparam int DIGIT_W = 4;   // BCD digit
  localparam int REQ_W   = 2;
  localparam int EVT_W   = 2;
  localparam int CFG_AW  = 4;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PRESS = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd2;

  // event codes
  localparam logic [EVT_W-1:0] EVT_NONE    = 2'd0;
  localparam logic [EVT_W-1:0] EVT_PAUSED  = 2'd1;
  localparam logic [EVT_W-1:0] EVT_RESUMED = 2'd2;

  // register indexes (word address)
  localparam logic [1:0] REG_SCROLL_INTERVAL = 2'd0;
  localparam logic [1:0] REG_REFRESH_GAP     = 2'd1;
  localparam logic [1:0] REG_DEBOUNCE        = 2'd2;

  typedef struct packed {
    logic [15:0] scroll_interval_ms;
    logic [7:0]  refresh_gap_ms;
    logic [15:0] debounce_ms;
  } cfg_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
    logic [DIGIT_W-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic               valid;
    logic [DIGIT_W-1:0] digit;
  } store_rd_t;

  typedef struct packed {
    logic [3:0]       digit_enable_n;
    logic [3:0]       bcd_lines;
    logic             pause_led;
    logic [EVT_W-1:0] event_code;
    logic             scroll_enabled;
  } result_t;

endpackage

[hdl/sssm_cfg.sv]
// ----------------------------------------------------------------------------
// sssm_cfg
// APB register file: scroll interval, refresh gap and debounce time.
// ----------------------------------------------------------------------------
module sssm_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sssm_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output sssm_pkg::cfg_t               cfg
);

  logic [15:0] scroll_interval_r;
  logic [7:0]  refresh_gap_r;
  logic [15:0] debounce_r;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_interval_r <= 16'd250;
      refresh_gap_r     <= 8'd5;
      debounce_r        <= 16'd100;
    end else if (wr_en) begin
      unique case (reg_idx)
        sssm_pkg::REG_SCROLL_INTERVAL: scroll_interval_r <= pwdata[15:0];
        sssm_pkg::REG_REFRESH_GAP:     refresh_gap_r     <= pwdata[7:0];
        sssm_pkg::REG_DEBOUNCE:        debounce_r        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sssm_pkg::REG_SCROLL_INTERVAL: prdata = {16'd0, scroll_interval_r};
      sssm_pkg::REG_REFRESH_GAP:     prdata = {24'd0, refresh_gap_r};
      sssm_pkg::REG_DEBOUNCE:        prdata = {16'd0, debounce_r};
      default:                       prdata = 32'd0;
    endcase
  end

  assign cfg.scroll_interval_ms = scroll_interval_r;
  assign cfg.refresh_gap_ms     = refresh_gap_r;
  assign cfg.debounce_ms        = debounce_r;

endmodule

[hdl/sssm_store.sv]
// ----------------------------------------------------------------------------
// sssm_store
// Digit memory with per-entry valid bits, one write and one registered read
// per cycle; a write to the address being read is forwarded.
// ----------------------------------------------------------------------------
module sssm_store #(
  parameter int NUM_DIGITS = 44
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sssm_pkg::store_wr_t           wr,
  input  logic [sssm_pkg::IDX_W-1:0]    rd_addr,
  output sssm_pkg::store_rd_t           rd
);

  localparam int AW = $clog2(NUM_DIGITS);

  logic [sssm_pkg::DIGIT_W-1:0] mem [NUM_DIGITS];
  logic [NUM_DIGITS-1:0]        valid_r;
  logic [sssm_pkg::DIGIT_W-1:0] mem_q_r;
  logic [sssm_pkg::DIGIT_W-1:0] fwd_data_r;
  logic                         fwd_r;
  logic                         rd_valid_r;
  logic                         hit;
  logic [AW-1:0]                wa;
  logic [AW-1:0]                ra;

  assign wa  = wr.addr[AW-1:0];
  assign ra  = rd_addr[AW-1:0];
  assign hit = wr.en && (wr.addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wa] <= wr.data;
    end
    mem_q_r    <= mem[ra];
    fwd_data_r <= wr.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      fwd_r      <= 1'b0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wa] <= 1'b1;
      end
      fwd_r      <= hit;
      rd_valid_r <= valid_r[ra] || hit;
    end
  end

  assign rd.valid = rd_valid_r;
  assign rd.digit = fwd_r ? fwd_data_r : mem_q_r;

endmodule

[hdl/sssm_ctrl.sv]
// ----------------------------------------------------------------------------
// sssm_ctrl
// Request processing: elapsed counters, refresh and scroll, debounced pause,
// digit loads. Prefetches the store entry under the next window position.
// ----------------------------------------------------------------------------
module sssm_ctrl #(
  parameter int NUM_DIGITS = 44
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [sssm_pkg::REQ_W-1:0]    req_type,
  input  logic [sssm_pkg::DIGIT_W-1:0]  digit_value,
  input  logic [sssm_pkg::IDX_W-1:0]    digit_index,
  input  sssm_pkg::cfg_t                cfg,
  output sssm_pkg::store_wr_t           st_wr,
  output logic [sssm_pkg::IDX_W-1:0]    st_rd_addr,
  input  sssm_pkg::store_rd_t           st_rd,
  output sssm_pkg::result_t             res
);

  localparam logic [5:0] CD_RELOAD   = 6'(NUM_DIGITS + 4);
  localparam logic [6:0] POS_DIG_END = 7'(NUM_DIGITS + 4);
  localparam logic [6:0] POS_END     = 7'(NUM_DIGITS + 8);
  localparam logic [5:0] IDX_LIMIT   = 6'(NUM_DIGITS);

  // what the prefetched position shows
  localparam logic [1:0] KIND_ZERO  = 2'd0;
  localparam logic [1:0] KIND_BLANK = 2'd1;
  localparam logic [1:0] KIND_MEM   = 2'd2;

  logic [1:0]  phase_r, phase_nxt;
  logic [5:0]  window_r, window_nxt;
  logic [5:0]  countdown_r, countdown_nxt;
  logic        scroll_on_r, scroll_on_nxt;
  logic [7:0]  refresh_el_r, refresh_el_nxt;
  logic [15:0] scroll_el_r, scroll_el_nxt;
  logic [15:0] press_el_r, press_el_nxt;
  logic [3:0]  bcd_r, bcd_nxt;
  logic [3:0]  enable_r, enable_nxt;
  logic        led_r, led_nxt;
  logic        padded_r, padded_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [1:0]  event_code;
  logic [6:0]  pos_nxt;
  logic [6:0]  slot_nxt;
  logic        entry_blank;
  logic [3:0]  entry_digit;

  assign entry_blank = (kind_r == KIND_BLANK);
  assign entry_digit = ((kind_r == KIND_MEM) && st_rd.valid) ? st_rd.digit : 4'd0;

  always_comb begin
    phase_nxt      = phase_r;
    window_nxt     = window_r;
    countdown_nxt  = countdown_r;
    scroll_on_nxt  = scroll_on_r;
    refresh_el_nxt = refresh_el_r;
    scroll_el_nxt  = scroll_el_r;
    press_el_nxt   = press_el_r;
    bcd_nxt        = bcd_r;
    enable_nxt     = enable_r;
    led_nxt        = led_r;
    padded_nxt     = padded_r;
    event_code     = sssm_pkg::EVT_NONE;
    st_wr.en       = 1'b0;
    st_wr.addr     = digit_index;
    st_wr.data     = digit_value;

    if (accept) begin
      unique case (req_type)
        sssm_pkg::REQ_TICK: begin
          if (refresh_el_r != 8'hFF)    refresh_el_nxt = refresh_el_r + 8'd1;
          if (scroll_el_r != 16'hFFFF)  scroll_el_nxt  = scroll_el_r + 16'd1;
          if (press_el_r != 16'hFFFF)   press_el_nxt   = press_el_r + 16'd1;
          if (refresh_el_nxt > cfg.refresh_gap_ms) begin
            enable_nxt = 4'hF;
            if (!entry_blank) begin
              enable_nxt = ~(4'b0001 << phase_r);
              if (entry_digit < 4'd10) bcd_nxt = entry_digit;
            end
            if (scroll_on_r && (scroll_el_nxt > cfg.scroll_interval_ms) &&
                (phase_r == 2'd3)) begin
              // wrap back to the start once all moves are used up
              if (countdown_r == 6'd0) begin
                window_nxt    = 6'd0;
                countdown_nxt = CD_RELOAD;
              end else begin
                window_nxt    = window_r + 6'd1;
                countdown_nxt = countdown_r - 6'd1;
              end
              scroll_el_nxt = 16'd0;
            end
            phase_nxt      = phase_r + 2'd1;
            refresh_el_nxt = 8'd0;
          end
        end
        sssm_pkg::REQ_PRESS: begin
          if (press_el_r >= cfg.debounce_ms) begin
            scroll_on_nxt = !scroll_on_r;
            event_code    = scroll_on_r ? sssm_pkg::EVT_PAUSED : sssm_pkg::EVT_RESUMED;
            led_nxt       = !led_r;
            press_el_nxt  = 16'd0;
          end
        end
        sssm_pkg::REQ_LOAD: begin
          if (digit_index < IDX_LIMIT) begin
            st_wr.en      = 1'b1;
            padded_nxt    = 1'b1;
            scroll_on_nxt = 1'b1;
            countdown_nxt = CD_RELOAD;
          end
        end
        default: ;
      endcase
    end
  end

  // classify the position the next item will see and start its read
  always_comb begin
    pos_nxt    = {1'b0, window_nxt} + {5'd0, phase_nxt};
    slot_nxt   = pos_nxt - 7'd4;
    st_rd_addr = '0;
    if (pos_nxt < 7'd4) begin
      kind_nxt = padded_nxt ? KIND_BLANK : KIND_ZERO;
    end else if (pos_nxt < POS_DIG_END) begin
      kind_nxt   = KIND_MEM;
      st_rd_addr = slot_nxt[5:0];
    end else if (pos_nxt < POS_END) begin
      kind_nxt = padded_nxt ? KIND_BLANK : KIND_ZERO;
    end else begin
      kind_nxt = KIND_BLANK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= 2'd0;
      window_r     <= 6'd0;
      countdown_r  <= 6'd0;
      scroll_on_r  <= 1'b0;
      refresh_el_r <= 8'd0;
      scroll_el_r  <= 16'd0;
      press_el_r   <= 16'd0;
      bcd_r        <= 4'd0;
      enable_r     <= 4'hF;
      led_r        <= 1'b0;
      padded_r     <= 1'b0;
      kind_r       <= KIND_ZERO;
    end else begin
      phase_r      <= phase_nxt;
      window_r     <= window_nxt;
      countdown_r  <= countdown_nxt;
      scroll_on_r  <= scroll_on_nxt;
      refresh_el_r <= refresh_el_nxt;
      scroll_el_r  <= scroll_el_nxt;
      press_el_r   <= press_el_nxt;
      bcd_r        <= bcd_nxt;
      enable_r     <= enable_nxt;
      led_r        <= led_nxt;
      padded_r     <= padded_nxt;
      kind_r       <= kind_nxt;
    end
  end

  assign res.digit_enable_n = enable_nxt;
  assign res.bcd_lines      = bcd_nxt;
  assign res.pause_led      = led_nxt;
  assign res.event_code     = event_code;
  assign res.scroll_enabled = scroll_on_nxt;

endmodule

[hdl/scrolling_seven_segment_mux_top.sv]
// ----------------------------------------------------------------------------
// scrolling_seven_segment_mux_top
// Four-digit multiplexed BCD display driver scrolling a NUM_DIGITS string.
// ----------------------------------------------------------------------------
// Takes one request per clock while the sink keeps up (millisecond tick, pause
// press or digit load) and returns one result per request through a one-deep
// output register, in the cycle after the request is accepted. in_tready is
// high while that register is empty or its result is taken in the same cycle,
// so requests follow back to back as long as the sink keeps out_tready high; a
// stalled sink holds the input. The digit under the next display position is
// read from the digit memory ahead of the request that shows it. Digit memory
// starts out as all zeros with no clearing pass after reset. Registers: scroll
// interval at 0x0, refresh gap at 0x4, debounce at 0x8.
module scrolling_seven_segment_mux_top #(
  parameter int NUM_DIGITS = 44
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [15:0]                  in_tdata,   // [3:0] digit_value, [9:4] digit_index
  input  logic [1:0]                   in_tuser,   // [1:0] req_type
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [3:0] digit_enable_n, [7:4] bcd_lines, [8] pause_led, [10:9] event_code,
  // [11] scroll_enabled
  output logic [15:0]                  out_tdata,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [sssm_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);

  sssm_pkg::cfg_t              cfg;
  sssm_pkg::store_wr_t         st_wr;
  sssm_pkg::store_rd_t         st_rd;
  sssm_pkg::result_t           res;
  sssm_pkg::result_t           res_r;
  logic [sssm_pkg::IDX_W-1:0]  st_rd_addr;
  logic                        out_valid_r;
  logic                        accept;

  assign cfg_pready = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;

  sssm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  sssm_store #(.NUM_DIGITS(NUM_DIGITS)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (st_wr),
    .rd_addr (st_rd_addr),
    .rd      (st_rd)
  );

  sssm_ctrl #(.NUM_DIGITS(NUM_DIGITS)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .req_type    (in_tuser),
    .digit_value (in_tdata[3:0]),
    .digit_index (in_tdata[9:4]),
    .cfg         (cfg),
    .st_wr       (st_wr),
    .st_rd_addr  (st_rd_addr),
    .st_rd       (st_rd),
    .res         (res)
  );

  // hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, res_r.scroll_enabled, res_r.event_code, res_r.pause_led,
                       res_r.bcd_lines, res_r.digit_enable_n};

endmodule
